/* hw/rtl/ppfd_pkg.sv */
// Package for the pulse pair frame decoder.
// Holds shared types, register indexes and protocol constants.
// No dependencies.
package ppfd_pkg;

    // Field and port widths
    localparam int PULSE_W   = 20;
    localparam int PERIOD_W  = 12;
    localparam int LAYOUT_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int SERIAL_W  = 32;
    localparam int BUTTON_W  = 4;
    localparam int COUNTER_W = 16;
    localparam int CHECK_W   = 16;
    localparam int BITSOUT_W = 6;

    // Frame sizing
    localparam int FRAME_WIDTH_DEF = 60;
    localparam int MIN_PULSES      = 20;
    localparam int MIN_BITS        = 40;
    localparam int PTOT_W          = 5;
    // Sync pair must start within the first four pairs
    localparam int SYNC_PULSE_LIMIT = 8;

    // Reset values of the registers
    localparam logic [PERIOD_W-1:0] BASE_PERIOD_RST = 12'd200;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LAYOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PERIOD  = 2'd1;

    // Slicing layouts; the unused code falls back to the last layout
    typedef enum logic [LAYOUT_W-1:0] {
        LAYOUT_A = 2'd0,
        LAYOUT_B = 2'd1,
        LAYOUT_C = 2'd2
    } layout_t;

    // Window classification of one pulse
    typedef struct packed {
        logic is_short;
        logic is_long;
        logic is_sync;
    } pulse_class_t;

endpackage

/* hw/rtl/ppfd_pulse_class.sv */
// Pulse window classifier: short, long and sync tests against the base period.
// Depends on ppfd_pkg.
// Windows are 60%..160% of one and two periods, using exact integer compares.
module ppfd_pulse_class (
    input  logic [ppfd_pkg::PULSE_W-1:0]  pulse,
    input  logic [ppfd_pkg::PERIOD_W-1:0] period,
    output ppfd_pkg::pulse_class_t        cls
);

    logic [22:0] p_x5;
    logic [22:0] p_x5_p5;
    logic [22:0] te_x3;
    logic [22:0] te_x6;
    logic [22:0] te_x8;
    logic [22:0] te_x16;

    // Scaled operands; floor(k*te/100) <= p is k*te < 100*(p+1)
    always_comb begin
        p_x5    = {1'b0, pulse, 2'b00} + {3'b000, pulse};
        p_x5_p5 = p_x5 + 23'd5;
        te_x3   = {10'd0, period, 1'b0} + {11'd0, period};
        te_x6   = {te_x3[21:0], 1'b0};
        te_x8   = {8'd0, period, 3'b000};
        te_x16  = {7'd0, period, 4'b0000};
    end

    // Window tests
    always_comb begin
        cls.is_short = (te_x3 < p_x5_p5) && (p_x5 <= te_x8);
        cls.is_long  = (te_x6 < p_x5_p5) && (p_x5 <= te_x16);
        cls.is_sync  = ({3'b000, pulse} > te_x3);
    end

endmodule

/* hw/rtl/pulse_pair_frame_decoder_top.sv */
// Pulse pair frame decoder: top level with input register, pair decode and result register.
// Depends on ppfd_pkg and ppfd_pulse_class.
// A final pulse's result goes from the input register through the pair decode into the result register.
// Throughput: one pulse per cycle; a final pulse stalls while the result register is full.
// Reset (aresetn, synchronous, active low) clears capture state and loads register defaults.
// No clearing pass: the block accepts pulses as soon as reset is released.
module pulse_pair_frame_decoder_top #(
    parameter int FRAME_WIDTH = ppfd_pkg::FRAME_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [ppfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppfd_pkg::CFG_DAT_W-1:0]    cfg_wdata,
    // pulse input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ppfd_pkg::PULSE_W-1:0]      s_pulse_us,
    input  logic                              s_last_pulse,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_valid_res,
    output logic [ppfd_pkg::SERIAL_W-1:0]     m_serial,
    output logic [ppfd_pkg::BUTTON_W-1:0]     m_button,
    output logic [ppfd_pkg::COUNTER_W-1:0]    m_counter,
    output logic [ppfd_pkg::CHECK_W-1:0]      m_check,
    output logic [ppfd_pkg::BITSOUT_W-1:0]    m_bits_decoded
);

    localparam int BITS_W = $clog2(FRAME_WIDTH + 1);
    localparam int PW     = ppfd_pkg::PULSE_W;
    localparam int PTW    = ppfd_pkg::PTOT_W;

    // Configuration registers
    logic [ppfd_pkg::LAYOUT_W-1:0] frame_layout_reg;
    logic [ppfd_pkg::PERIOD_W-1:0] base_period_reg;

    // Input register
    logic          in_vld_reg;
    logic [PW-1:0] pulse_reg;
    logic          last_reg;

    // Capture state
    logic [FRAME_WIDTH-1:0] frame_reg, frame_next;
    logic [BITS_W-1:0]      bits_reg, bits_next;
    logic [PW-1:0]          held_reg, held_next;
    logic                   phase_reg, phase_next;
    logic [PTW-1:0]         ptot_reg, ptot_next;
    logic                   stopped_reg, stopped_next;
    logic                   sync_reg, sync_next;

    // Result register
    logic                             m_valid_reg;
    logic                             res_valid_reg;
    logic [ppfd_pkg::SERIAL_W-1:0]    serial_reg, serial_next;
    logic [ppfd_pkg::BUTTON_W-1:0]    button_reg, button_next;
    logic [ppfd_pkg::COUNTER_W-1:0]   counter_reg, counter_next;
    logic [ppfd_pkg::CHECK_W-1:0]     check_reg, check_next;
    logic [ppfd_pkg::BITSOUT_W-1:0]   bitsout_reg;
    logic                             res_valid_next;

    logic                  stage_fire;
    logic                  out_load;
    ppfd_pkg::pulse_class_t cls_a;
    ppfd_pkg::pulse_class_t cls_b;
    logic [63:0]           fview;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_layout_reg <= '0;
            base_period_reg  <= ppfd_pkg::BASE_PERIOD_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == ppfd_pkg::CFG_FRAME_LAYOUT) begin
                frame_layout_reg <= cfg_wdata[ppfd_pkg::LAYOUT_W-1:0];
            end else if (cfg_index == ppfd_pkg::CFG_BASE_PERIOD) begin
                base_period_reg <= cfg_wdata;
            end
        end
    end

    // Handshake: a final pulse waits only for room in the result register
    assign stage_fire = in_vld_reg && (!last_reg || !m_valid_reg || m_ready);
    assign out_load   = stage_fire && last_reg;
    assign s_ready    = !in_vld_reg || stage_fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            pulse_reg <= s_pulse_us;
            last_reg  <= s_last_pulse;
        end
    end

    // Window classifiers for the held pulse and the current pulse
    ppfd_pulse_class u_class_a (
        .pulse  (held_reg),
        .period (base_period_reg),
        .cls    (cls_a)
    );

    ppfd_pulse_class u_class_b (
        .pulse  (pulse_reg),
        .period (base_period_reg),
        .cls    (cls_b)
    );

    // Pair decode and capture update
    always_comb begin
        frame_next   = frame_reg;
        bits_next    = bits_reg;
        held_next    = held_reg;
        phase_next   = phase_reg;
        stopped_next = stopped_reg;
        sync_next    = sync_reg;
        ptot_next    = ptot_reg;
        if (!phase_reg) begin
            held_next  = pulse_reg;
            phase_next = 1'b1;
        end else begin
            phase_next = 1'b0;
            priority if (!sync_reg && (ptot_reg <= PTW'(ppfd_pkg::SYNC_PULSE_LIMIT))
                         && cls_a.is_sync && cls_b.is_sync) begin
                // sync pair restarts the frame
                sync_next    = 1'b1;
                frame_next   = '0;
                bits_next    = '0;
                stopped_next = 1'b0;
            end else if (stopped_reg || (bits_reg >= BITS_W'(FRAME_WIDTH))) begin
                // frame closed
            end else if (cls_a.is_short && cls_b.is_long) begin
                frame_next = {frame_reg[FRAME_WIDTH-2:0], 1'b0};
                bits_next  = bits_reg + 1'b1;
            end else if (cls_a.is_long && cls_b.is_short) begin
                frame_next = {frame_reg[FRAME_WIDTH-2:0], 1'b1};
                bits_next  = bits_reg + 1'b1;
            end else begin
                stopped_next = 1'b1;
            end
        end
        if (ptot_reg < PTW'(ppfd_pkg::MIN_PULSES)) begin
            ptot_next = ptot_reg + 1'b1;
        end
    end

    // Result slicing from the updated frame
    always_comb begin
        fview          = 64'(frame_next);
        res_valid_next = (ptot_next >= PTW'(ppfd_pkg::MIN_PULSES))
                         && (bits_next >= BITS_W'(ppfd_pkg::MIN_BITS));
        serial_next    = '0;
        button_next    = '0;
        counter_next   = '0;
        check_next     = '0;
        if (res_valid_next) begin
            unique case (ppfd_pkg::layout_t'(frame_layout_reg))
                ppfd_pkg::LAYOUT_A: begin
                    serial_next  = {fview[15:0], fview[47:32]};
                    button_next  = fview[51:48];
                    counter_next = {4'd0, fview[31:20]};
                    check_next   = {8'd0, fview[59:52]};
                end
                ppfd_pkg::LAYOUT_B: begin
                    serial_next  = {8'd0, fview[23:0]};
                    button_next  = fview[27:24];
                    counter_next = fview[43:28];
                    check_next   = fview[59:44];
                end
                default: begin
                    serial_next  = fview[31:0];
                    button_next  = fview[43:40];
                    counter_next = {4'd0, fview[55:44]};
                    check_next   = {12'd0, fview[59:56]};
                end
            endcase
        end
    end

    // Capture state; the final pulse returns it to reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg   <= '0;
            bits_reg    <= '0;
            held_reg    <= '0;
            phase_reg   <= 1'b0;
            ptot_reg    <= '0;
            stopped_reg <= 1'b0;
            sync_reg    <= 1'b0;
        end else if (stage_fire) begin
            if (last_reg) begin
                frame_reg   <= '0;
                bits_reg    <= '0;
                held_reg    <= '0;
                phase_reg   <= 1'b0;
                ptot_reg    <= '0;
                stopped_reg <= 1'b0;
                sync_reg    <= 1'b0;
            end else begin
                frame_reg   <= frame_next;
                bits_reg    <= bits_next;
                held_reg    <= held_next;
                phase_reg   <= phase_next;
                ptot_reg    <= ptot_next;
                stopped_reg <= stopped_next;
                sync_reg    <= sync_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_valid_reg <= res_valid_next;
            serial_reg    <= serial_next;
            button_reg    <= button_next;
            counter_reg   <= counter_next;
            check_reg     <= check_next;
            bitsout_reg   <= bits_next[ppfd_pkg::BITSOUT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_valid_res    = res_valid_reg;
    assign m_serial       = serial_reg;
    assign m_button       = button_reg;
    assign m_counter      = counter_reg;
    assign m_check        = check_reg;
    assign m_bits_decoded = bitsout_reg;

    // Checks
    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= BITS_W'(FRAME_WIDTH))
        else $error("bit count beyond frame width");

    a_ptot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptot_reg <= PTW'(ppfd_pkg::MIN_PULSES))
        else $error("pulse count beyond saturation");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (ptot_reg == '0) && !phase_reg && (bits_reg == '0) && !sync_reg)
        else $error("capture state not cleared after final pulse");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_valid_reg) |-> (serial_reg == '0) && (check_reg == '0))
        else $error("invalid result carries nonzero fields");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(out_load))
        else $error("result raised without a final pulse");

endmodule

/* verif/pulse_pair_frame_decoder_top_tb.sv */
// Self-checking testbench for pulse_pair_frame_decoder_top.
// Depends on ppfd_pkg and the decoder RTL. A scoreboard class predicts every
// frame result from the accepted pulses and checks the result channel against it.
module pulse_pair_frame_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PULSE_W        = ppfd_pkg::PULSE_W;
    localparam int CFG_DAT_W      = ppfd_pkg::CFG_DAT_W;
    localparam int BITSOUT_W      = ppfd_pkg::BITSOUT_W;
    localparam int FW             = ppfd_pkg::FRAME_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_SHOWN      = 10;
    localparam int PULSE_MAX      = (1 << PULSE_W) - 1;

    typedef struct packed {
        logic                           valid_res;
        logic [ppfd_pkg::SERIAL_W-1:0]  serial;
        logic [ppfd_pkg::BUTTON_W-1:0]  button;
        logic [ppfd_pkg::COUNTER_W-1:0] counter;
        logic [ppfd_pkg::CHECK_W-1:0]   check;
        logic [BITSOUT_W-1:0]           bits_decoded;
    } frame_result_t;

    // Frame predictor plus the queue of frame results still owed by the block
    class frame_scoreboard;
        logic [ppfd_pkg::LAYOUT_W-1:0] layout;
        logic [ppfd_pkg::PERIOD_W-1:0] period;
        logic [FW-1:0]                 frame_bits;
        int unsigned                   bit_total;
        int unsigned                   held_pulse;
        bit                            pair_phase;
        int unsigned                   pulse_total;
        bit                            decode_stopped;
        bit                            sync_seen;
        frame_result_t                 pending_q[$];
        int unsigned                   errors;

        function new();
            layout = ppfd_pkg::LAYOUT_A;
            period = ppfd_pkg::BASE_PERIOD_RST;
            errors = 0;
            clear_capture();
        endfunction

        function void clear_capture();
            frame_bits     = '0;
            bit_total      = 0;
            held_pulse     = 0;
            pair_phase     = 1'b0;
            pulse_total    = 0;
            decode_stopped = 1'b0;
            sync_seen      = 1'b0;
        endfunction

        // Accepted pulse request: pair decode, and on the flagged pulse the frame result
        function void note_pulse(logic [PULSE_W-1:0] pulse, logic last);
            int unsigned   te, s_lo, s_hi, l_lo, l_hi, a, b;
            bit            a_short, a_long, b_short, b_long;
            logic [FW-1:0] f;
            frame_result_t res;
            te   = 32'(period);
            s_lo = te * 60 / 100;
            s_hi = te * 160 / 100;
            l_lo = te * 120 / 100;
            l_hi = te * 320 / 100;
            if (!pair_phase) begin
                held_pulse = 32'(pulse);
                pair_phase = 1'b1;
            end else begin
                a = held_pulse;
                b = 32'(pulse);
                pair_phase = 1'b0;
                a_short = a >= s_lo && a <= s_hi;
                a_long  = a >= l_lo && a <= l_hi;
                b_short = b >= s_lo && b <= s_hi;
                b_long  = b >= l_lo && b <= l_hi;
                // pulse_total still counts the closing pulse's predecessors here
                if (!sync_seen && pulse_total - 1 < ppfd_pkg::SYNC_PULSE_LIMIT &&
                    a > te * 3 && b > te * 3) begin
                    sync_seen      = 1'b1;
                    frame_bits     = '0;
                    bit_total      = 0;
                    decode_stopped = 1'b0;
                end else if (!decode_stopped && bit_total < FW) begin
                    if (a_short && b_long) begin
                        frame_bits = {frame_bits[FW-2:0], 1'b0};
                        bit_total++;
                    end else if (a_long && b_short) begin
                        frame_bits = {frame_bits[FW-2:0], 1'b1};
                        bit_total++;
                    end else begin
                        decode_stopped = 1'b1;
                    end
                end
            end
            if (pulse_total < ppfd_pkg::MIN_PULSES)
                pulse_total++;
            if (!last)
                return;

            // Slice the frame per layout; the unused layout code behaves as the last one
            f = frame_bits;
            res = '0;
            res.bits_decoded = BITSOUT_W'(bit_total);
            if (pulse_total >= ppfd_pkg::MIN_PULSES && bit_total >= ppfd_pkg::MIN_BITS) begin
                res.valid_res = 1'b1;
                case (layout)
                    ppfd_pkg::LAYOUT_A: begin
                        res.serial  = {f[15:0], f[47:32]};
                        res.button  = f[51:48];
                        res.counter = {4'd0, f[31:20]};
                        res.check   = {8'd0, f[59:52]};
                    end
                    ppfd_pkg::LAYOUT_B: begin
                        res.serial  = {8'd0, f[23:0]};
                        res.button  = f[27:24];
                        res.counter = f[43:28];
                        res.check   = f[59:44];
                    end
                    default: begin
                        res.serial  = f[31:0];
                        res.button  = f[43:40];
                        res.counter = {4'd0, f[55:44]};
                        res.check   = {12'd0, f[59:56]};
                    end
                endcase
            end
            pending_q.push_back(res);
            clear_capture();
        endfunction

        // Accepted result request against the oldest owed frame result
        function void check_result(frame_result_t got);
            frame_result_t want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("frame result with none owed: valid=%0d serial=%h button=%h counter=%h check=%h bits=%0d",
                             got.valid_res, got.serial, got.button, got.counter,
                             got.check, got.bits_decoded);
                return;
            end
            want = pending_q.pop_front();
            if (want.valid_res !== got.valid_res || want.serial !== got.serial ||
                want.button !== got.button || want.counter !== got.counter ||
                want.check !== got.check || want.bits_decoded !== got.bits_decoded) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("frame result mismatch at %0t", $realtime);
                    $display("  expected valid=%0d serial=%h button=%h counter=%h check=%h bits=%0d",
                             want.valid_res, want.serial, want.button, want.counter,
                             want.check, want.bits_decoded);
                    $display("  actual   valid=%0d serial=%h button=%h counter=%h check=%h bits=%0d",
                             got.valid_res, got.serial, got.button, got.counter,
                             got.check, got.bits_decoded);
                end
            end
        endfunction
    endclass

    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           cfg_wr_en    = 1'b0;
    logic [ppfd_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_DAT_W-1:0]           cfg_wdata    = '0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [PULSE_W-1:0]             s_pulse_us   = '0;
    logic                           s_last_pulse = 1'b0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic                           m_valid_res;
    logic [ppfd_pkg::SERIAL_W-1:0]  m_serial;
    logic [ppfd_pkg::BUTTON_W-1:0]  m_button;
    logic [ppfd_pkg::COUNTER_W-1:0] m_counter;
    logic [ppfd_pkg::CHECK_W-1:0]   m_check;
    logic [BITSOUT_W-1:0]           m_bits_decoded;

    frame_scoreboard      frame_sb;
    logic [PULSE_W-1:0]   capture_q[$];
    int                   pulses_sent    = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_request   = 0;
    int                   hold_left      = 0;
    int                   quiet_cycles   = 0;

    pulse_pair_frame_decoder_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pulse_us     (s_pulse_us),
        .s_last_pulse   (s_last_pulse),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_serial       (m_serial),
        .m_button       (m_button),
        .m_counter      (m_counter),
        .m_check        (m_check),
        .m_bits_decoded (m_bits_decoded)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result side: check accepted results, then pick next ready (long hold on request)
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            frame_sb.check_result({m_valid_res, m_serial, m_button, m_counter,
                                   m_check, m_bits_decoded});
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no request moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("pulse_pair_frame_decoder_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One pulse request: optional idle gap, then hold valid until accepted
    task automatic send_pulse(input logic [PULSE_W-1:0] pulse, input logic last);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pulse_us   <= pulse;
        s_last_pulse <= last;
        do @(posedge aclk); while (!s_ready);
        frame_sb.note_pulse(pulse, last);
        pulses_sent++;
    endtask

    // Send the built capture, flagging its final pulse
    task automatic send_capture();
        int n;
        n = capture_q.size();
        for (int i = 0; i < n; i++)
            send_pulse(capture_q[i], i == n - 1);
        capture_q.delete();
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (frame_sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [CFG_DAT_W-1:0] layout,
                              input logic [CFG_DAT_W-1:0] period);
        cfg_wr_en <= 1'b1;
        cfg_index <= ppfd_pkg::CFG_FRAME_LAYOUT;
        cfg_wdata <= layout;
        @(posedge aclk);
        cfg_index <= ppfd_pkg::CFG_BASE_PERIOD;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        frame_sb.layout = layout[ppfd_pkg::LAYOUT_W-1:0];
        frame_sb.period = period;
    endtask

    // Value in [lo, hi], hitting the bounds now and then
    function automatic logic [PULSE_W-1:0] pick_window(int unsigned lo, int unsigned hi);
        case ($urandom_range(9))
            0:       return PULSE_W'(lo);
            1:       return PULSE_W'(hi);
            default: return PULSE_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic void push_bit(bit one);
        int unsigned te;
        logic [PULSE_W-1:0] short_p, long_p;
        te = 32'(frame_sb.period);
        short_p = pick_window(te * 60 / 100, te * 160 / 100);
        long_p  = pick_window(te * 120 / 100, te * 320 / 100);
        capture_q.push_back(one ? long_p : short_p);
        capture_q.push_back(one ? short_p : long_p);
    endfunction

    function automatic void push_sync();
        int unsigned te;
        te = 32'(frame_sb.period);
        repeat (2) begin
            if ($urandom_range(9) == 0)
                capture_q.push_back(PULSE_W'(PULSE_MAX));
            else
                capture_q.push_back(PULSE_W'(te * 3 + 1 + $urandom_range(te * 2)));
        end
    endfunction

    function automatic logic [PULSE_W-1:0] noise_pulse();
        int unsigned te;
        te = 32'(frame_sb.period);
        case ($urandom_range(4))
            0:       return PULSE_W'($urandom_range(PULSE_MAX, 0));
            1:       return PULSE_W'($urandom_range(te * 4, 0));
            2:       return pick_window(te * 60 / 100, te * 320 / 100);
            3:       return $urandom_range(1) ? PULSE_W'(PULSE_MAX) : '0;
            default: return PULSE_W'($urandom_range(te * 3 + 1, te * 3));
        endcase
    endfunction

    // Pair that usually breaks decoding: same class twice, just outside a window, or noise
    function automatic void push_broken();
        int unsigned te;
        te = 32'(frame_sb.period);
        case ($urandom_range(3))
            0: begin
                capture_q.push_back(PULSE_W'(te * 60 / 100));
                capture_q.push_back(PULSE_W'(te * 60 / 100));
            end
            1: begin
                capture_q.push_back(PULSE_W'(te * 320 / 100 + 1));
                capture_q.push_back(PULSE_W'(te * 60 / 100));
            end
            2: begin
                capture_q.push_back(PULSE_W'(te * 160 / 100));
                capture_q.push_back(PULSE_W'(te * 120 / 100 - (te >= 2 ? 1 : 0)));
            end
            default: begin
                capture_q.push_back(noise_pulse());
                capture_q.push_back(noise_pulse());
            end
        endcase
    endfunction

    // Well-formed capture: lead-in pairs, sync, data bits, sometimes a break or stray tail
    function automatic void build_frame();
        int unsigned nbits, cut, pick;
        repeat ($urandom_range(3)) push_bit(1'($urandom_range(1)));
        if ($urandom_range(9) == 0)
            push_broken();
        push_sync();
        pick = $urandom_range(99);
        if (pick < 70)
            nbits = $urandom_range(64, 40);
        else if (pick < 85)
            nbits = $urandom_range(39, 20);
        else
            nbits = $urandom_range(19, 0);
        cut = ($urandom_range(6) == 0) ? $urandom_range(nbits) : nbits + 1;
        for (int i = 0; i < nbits; i++) begin
            if (i == cut)
                push_broken();
            push_bit(1'($urandom_range(1)));
        end
        if ($urandom_range(9) == 0)
            push_sync();
        if ($urandom_range(4) == 0)
            capture_q.push_back(noise_pulse());
    endfunction

    function automatic void build_noise(int unsigned max_len);
        repeat ($urandom_range(max_len, 1)) capture_q.push_back(noise_pulse());
    endfunction

    task automatic run_phase(input int layout, input int period, input int idle_pct,
                             input int stall_pct, input int items);
        int stop;
        settle();
        write_regs(CFG_DAT_W'(layout), CFG_DAT_W'(period));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop = pulses_sent + items;
        while (pulses_sent < stop) begin
            if ($urandom_range(9) < 6)
                build_frame();
            else
                build_noise(12);
            send_capture();
        end
    endtask

    initial begin
        int stop;
        frame_sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: lone unpaired final pulse
        capture_q = '{20'd0};
        send_capture();
        // Directed: max-width sync, bit 0, bit 1, a stopping pair, pair closed by the flag
        capture_q = '{20'hFFFFF, 20'hFFFFF, 20'd200, 20'd400, 20'd400, 20'd200,
                      20'd100, 20'd100, 20'd200, 20'd400};
        send_capture();
        // Directed: bit and stop before the sync are discarded, then an unpaired final pulse
        capture_q = '{20'd200, 20'd400, 20'd100, 20'd100, 20'd700, 20'd700,
                      20'd400, 20'd200, 20'd123};
        send_capture();

        // Random phases over register settings and idling modes
        run_phase(ppfd_pkg::LAYOUT_A, ppfd_pkg::BASE_PERIOD_RST, 0, 0, 240);
        run_phase(ppfd_pkg::LAYOUT_B, 1, 50, 0, 240);
        run_phase(ppfd_pkg::LAYOUT_C, 4095, 0, 50, 240);
        run_phase(3, 0, 26, 26, 240);
        run_phase(ppfd_pkg::LAYOUT_C, $urandom_range(4095, 1), 0, 0, 240);
        run_phase(ppfd_pkg::LAYOUT_B, $urandom_range(60, 1), 26, 26, 240);
        run_phase(ppfd_pkg::LAYOUT_A, $urandom_range(4095, 1), 50, 0, 240);

        // Back-pressure: receiver holds off while short captures keep coming
        settle();
        write_regs(CFG_DAT_W'($urandom_range(3)), ppfd_pkg::BASE_PERIOD_RST);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        stop = pulses_sent + 120;
        while (pulses_sent < stop) begin
            build_noise(3);
            send_capture();
        end

        recv_stall_pct = 0;
        settle();
        if (frame_sb.errors == 0)
            $display("pulse_pair_frame_decoder_top verification clean");
        else
            $display("pulse_pair_frame_decoder_top verification failed");
        $finish;
    end

endmodule
